@@ hdl/frame_buffer_pool_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// frame buffer pool allocator assertion macros
// concurrent checks on the clk/rst domain, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef FRAME_BUFFER_POOL_ALLOCATOR_ASSERT_SVH
`define FRAME_BUFFER_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH

`define FBPA_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fbpa check failed");

`define FBPA_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbpa sequence check failed");

`else

`define FBPA_CHECK(lbl, prop)

`define FBPA_CHECK_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// types, constants and helpers shared by the pool allocator cells and top
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int REG_W       = 5;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    USE_FREE = 2'd0,
    USE_MAIN = 2'd1,
    USE_PREP = 2'd2
  } use_t;

  typedef struct packed {
    op_t                operation;
    logic signed [15:0] page_id;
    logic               for_main;
    logic [3:0]         entry_index;
  } in_word_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] granted_index;
    logic       is_device_buffer;
    logic       has_picture;
  } out_word_t;

  // "some earlier entry is a candidate" flags rippling down the chain
  typedef struct packed {
    logic matched;
    logic blank;
    logic free;
  } chain_t;

  typedef struct packed {
    logic grant;
    logic picture;
  } cell_out_t;

  function automatic logic [ID_BITS-1:0] to_id(input logic signed [15:0] p);
    logic signed [ID_BITS+15:0] ext;
    ext = (ID_BITS + 16)'(p);
    return ext[ID_BITS-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_pool(input logic [REG_W-1:0] r);
    logic [CNT_W-1:0] n;
    if (r == '0) begin
      n = CNT_W'(1);
    end else if (32'(r) > MAX_ENTRIES) begin
      n = CNT_W'(MAX_ENTRIES);
    end else begin
      n = CNT_W'(r);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fbpa_cell.sv @@
// ----------------------------------------------------------------------------
// fbpa_cell
// one pool entry: id, use state and picture flag, with its link in the
// priority search chain and its own update on every command
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [fbpa_pkg::IDX_W-1:0] index,
  input  wire logic [fbpa_pkg::CNT_W-1:0] pool_size,
  input  wire logic                    cmd_valid,
  input  wire fbpa_pkg::in_word_t      cmd,
  input  wire fbpa_pkg::chain_t        chain_in,
  input  wire fbpa_pkg::chain_t        chain_end,
  output fbpa_pkg::chain_t             chain_out,
  output fbpa_pkg::cell_out_t          result
);
  import fbpa_pkg::*;

  logic [ID_BITS-1:0] page_id;
  use_t               use_state;
  logic               filled;

  logic [ID_BITS-1:0] req_id;
  logic               active;
  logic               is_free;
  chain_t             mine;
  logic               acquire;
  logic               win_match;
  logic               win_blank;
  logic               win_free;
  logic               win_fallback;
  logic               grant;
  logic               targeted;
  logic               is_device;

  assign req_id    = to_id(cmd.page_id);
  assign active    = CNT_W'(index) < pool_size;
  assign is_free   = active && (use_state == USE_FREE);
  assign is_device = (CNT_W'(index) == pool_size - CNT_W'(1)) && (pool_size > CNT_W'(1));

  assign mine.matched = is_free && (page_id == req_id);
  assign mine.blank   = is_free && !filled;
  assign mine.free    = is_free;

  assign chain_out = chain_in | mine;

  assign acquire      = cmd_valid && (cmd.operation == OP_ACQUIRE);
  assign win_match    = mine.matched && !chain_in.matched;
  assign win_blank    = !chain_end.matched && mine.blank && !chain_in.blank;
  assign win_free     = !chain_end.matched && !chain_end.blank && mine.free && !chain_in.free;
  assign win_fallback = !chain_end.free && cmd.for_main && (index == '0);
  assign grant        = acquire && (win_match || win_blank || win_free || win_fallback);
  assign targeted     = active && (cmd.entry_index == 4'(index));

  assign result.grant   = grant;
  assign result.picture = grant && win_match && filled;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_id   <= '0;
      use_state <= USE_FREE;
      filled    <= 1'b0;
    end else if (cmd_valid) begin
      unique case (cmd.operation)
        OP_ACQUIRE: begin
          if (grant) begin
            use_state <= cmd.for_main ? USE_MAIN : USE_PREP;
            if (!win_match) begin
              page_id <= req_id;
              filled  <= 1'b0;
            end
          end
        end
        OP_RELEASE: begin
          if (targeted) begin
            use_state <= USE_FREE;
            if (page_id == '1) begin
              filled <= 1'b0;
            end
          end
        end
        OP_MARK: begin
          if (targeted) begin
            filled <= 1'b1;
          end
        end
        OP_INIT: begin
          page_id   <= '0;
          filled    <= 1'b0;
          use_state <= is_device ? USE_MAIN : USE_FREE;
        end
        default: begin
          use_state <= use_state;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/frame_buffer_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// frame_buffer_pool_allocator
// page buffer pool with priority acquire, release, fill marking and init
// ----------------------------------------------------------------------------
// Each command runs as follows: start is taken when busy is low, busy is
// high for the following cycle while the command ripples through the chain
// of sixteen entry cells and commits, and the result word appears on the
// result port with done high for one cycle after that. The next command may
// be started in the cycle done is high. The result must be captured in that
// cycle; there is no way to hold it. pool_entries sets the active entries at
// once; the device entry is set up only at the next init command.
`default_nettype none

`include "frame_buffer_pool_allocator_assert.svh"

module frame_buffer_pool_allocator (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire fbpa_pkg::in_word_t   cmd,
  output logic                      done,
  output fbpa_pkg::out_word_t       result,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import fbpa_pkg::*;

  logic [REG_W-1:0] pool_entries;
  logic [CNT_W-1:0] pool_size;
  in_word_t         cmd_q;

  chain_t             chain [MAX_ENTRIES+1];
  cell_out_t          cell_res [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] grant_vec;

  logic             grant_any;
  logic [IDX_W-1:0] grant_idx;
  logic             grant_pic;
  logic             is_acq;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(pool_entries) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_entries <= REG_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      pool_entries <= pwdata[REG_W-1:0];
    end
  end

  assign pool_size = clamp_pool(pool_entries);

  // command sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start && !busy;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  // entry chain
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    fbpa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .index     (IDX_W'(i)),
      .pool_size (pool_size),
      .cmd_valid (busy),
      .cmd       (cmd_q),
      .chain_in  (chain[i]),
      .chain_end (chain[MAX_ENTRIES]),
      .chain_out (chain[i+1]),
      .result    (cell_res[i])
    );
    assign grant_vec[i] = cell_res[i].grant;
  end

  always_comb begin
    grant_idx = '0;
    grant_pic = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      grant_idx = grant_idx | (cell_res[i].grant ? IDX_W'(i) : '0);
      grant_pic = grant_pic | cell_res[i].picture;
    end
  end

  assign grant_any = |grant_vec;
  assign is_acq    = (cmd_q.operation == OP_ACQUIRE);

  always_ff @(posedge clk) begin
    if (busy) begin
      result.granted          <= !is_acq || grant_any;
      result.granted_index    <= is_acq ? 4'(grant_idx) : 4'd0;
      result.is_device_buffer <= is_acq && grant_any &&
                                 (CNT_W'(grant_idx) == pool_size - CNT_W'(1));
      result.has_picture      <= is_acq && grant_pic;
    end
  end

  `FBPA_CHECK(grant_single, $onehot0(grant_vec))
  `FBPA_CHECK_NEXT(start_takes_one_cycle, start && !busy, busy && !done)
  `FBPA_CHECK_NEXT(busy_then_result, busy, done && !busy)
  `FBPA_CHECK(no_grant_when_idle, !busy |-> (grant_vec == '0))

endmodule

`default_nettype wire

@@ verif/frame_buffer_pool_allocator_test.sv @@
// ----------------------------------------------------------------------------
// frame_buffer_pool_allocator_test
// drives acquire, release, mark and init commands across many pool sizes and
// checks every result word against a behavioral copy of the entry pool
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_pool_allocator_test;
  import fbpa_pkg::*;

  localparam logic [2:0] POOL_ADDR     = 3'd0;
  localparam logic [2:0] SPARE_ADDR    = 3'd4;
  localparam int         SEGMENTS      = 15;
  localparam int         SEG_ITEMS     = 104;
  localparam int         QUIET_LIMIT   = 1000;
  localparam logic [4:0] SEG_POOL [SEGMENTS] =
    '{5'd2, 5'd0, 5'd16, 5'd3, 5'd31, 5'd5, 5'd1, 5'd8, 5'd17, 5'd4,
      5'd16, 5'd2, 5'd12, 5'd0, 5'd6};

  class grant_board;
    logic [15:0] page_ids [MAX_ENTRIES];
    use_t        holders  [MAX_ENTRIES];
    logic        filled   [MAX_ENTRIES];
    logic [4:0]  pool_reg;
    out_word_t   pending_grants [$];
    int          errors;

    function new();
      pool_reg = 5'd1;
      errors = 0;
      rebuild();
    endfunction

    function int unsigned live_entries();
      if (pool_reg == 5'd0) return 1;
      if (pool_reg > MAX_ENTRIES) return MAX_ENTRIES;
      return pool_reg;
    endfunction

    function void rebuild();
      int i;
      for (i = 0; i < MAX_ENTRIES; i++) begin
        page_ids[i] = '0;
        holders[i] = USE_FREE;
        filled[i] = 1'b0;
      end
      if (live_entries() > 1) holders[live_entries() - 1] = USE_MAIN;
    endfunction

    function void set_pool(logic [4:0] v);
      pool_reg = v;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    // predicts the result word of one accepted command and updates the pool
    function void note_cmd(in_word_t w);
      out_word_t   r;
      int unsigned n;
      int          i;
      int          g;
      logic        hit;
      logic [15:0] id;
      use_t        who;
      r = '0;
      r.granted = 1'b1;
      n = live_entries();
      id = w.page_id;
      who = w.for_main ? USE_MAIN : USE_PREP;
      hit = 1'b0;
      g = 0;
      case (w.operation)
        OP_RELEASE: begin
          if (w.entry_index < n) begin
            holders[w.entry_index] = USE_FREE;
            if (page_ids[w.entry_index] == '1) filled[w.entry_index] = 1'b0;
          end
        end
        OP_MARK: begin
          if (w.entry_index < n) filled[w.entry_index] = 1'b1;
        end
        OP_INIT: begin
          rebuild();
        end
        default: begin
          for (i = 0; i < n && !hit; i++) begin
            if (holders[i] == USE_FREE && page_ids[i] == id) begin
              hit = 1'b1;
              g = i;
            end
          end
          for (i = 0; i < n && !hit; i++) begin
            if (holders[i] == USE_FREE && !filled[i]) begin
              hit = 1'b1;
              g = i;
              page_ids[i] = id;
            end
          end
          for (i = 0; i < n && !hit; i++) begin
            if (holders[i] == USE_FREE) begin
              hit = 1'b1;
              g = i;
              page_ids[i] = id;
              filled[i] = 1'b0;
            end
          end
          if (!hit && who == USE_MAIN) begin
            hit = 1'b1;
            g = 0;
            page_ids[0] = id;
            filled[0] = 1'b0;
          end
          if (!hit) begin
            r.granted = 1'b0;
          end else begin
            holders[g] = who;
            r.granted_index = 4'(g);
            r.is_device_buffer = (g == n - 1);
            r.has_picture = filled[g];
          end
        end
      endcase
      pending_grants.push_back(r);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected result word: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      compare_field("granted", 4'(want.granted), 4'(got.granted));
      compare_field("granted_index", want.granted_index, got.granted_index);
      compare_field("is_device_buffer", 4'(want.is_device_buffer),
                    4'(got.is_device_buffer));
      compare_field("has_picture", 4'(want.has_picture), 4'(got.has_picture));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    cmd;
  logic        done;
  out_word_t   result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  grant_board  board;
  int          quiet_cycles = 0;

  frame_buffer_pool_allocator dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_word(result);
      if (start && !busy) board.note_cmd(cmd);
      if (done || (start && !busy) || (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic in_word_t make_cmd(op_t op, logic signed [15:0] id, logic m,
                                        logic [3:0] idx);
    in_word_t w;
    w.operation = op;
    w.page_id = id;
    w.for_main = m;
    w.entry_index = idx;
    return w;
  endfunction

  // small ids dominate so that matches and reuse happen often
  function automatic logic signed [15:0] pick_id();
    int s;
    s = $urandom_range(9);
    if (s < 6) return 16'($urandom_range(5));
    if (s == 6) return '1;
    if (s == 7) return 16'($urandom_range(32767));
    return 16'($urandom);
  endfunction

  function automatic in_word_t random_cmd(int unsigned n);
    in_word_t w;
    int       r;
    r = $urandom_range(99);
    if (r < 50) w.operation = OP_ACQUIRE;
    else if (r < 78) w.operation = OP_RELEASE;
    else if (r < 96) w.operation = OP_MARK;
    else w.operation = OP_INIT;
    w.page_id = pick_id();
    w.for_main = 1'($urandom_range(1));
    if ($urandom_range(9) < 8) w.entry_index = 4'($urandom_range(n - 1));
    else w.entry_index = 4'($urandom_range(15));
    return w;
  endfunction

  task automatic send_cmd(input in_word_t w);
    start <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_pool_reg();
    logic [31:0] rd;
    apb_access(1'b0, POOL_ADDR, '0, rd);
    if (rd !== 32'(board.pool_reg)) begin
      $display("%0t pool_entries readback mismatch: expected %0h, actual %0h",
               $time, board.pool_reg, rd);
      board.errors++;
    end
  endtask

  task automatic set_pool_size(input logic [4:0] v);
    logic [31:0] rd;
    apb_access(1'b1, POOL_ADDR, 32'(v), rd);
    board.set_pool(v);
    check_pool_reg();
  endtask

  initial begin
    int seg;
    int k;
    int idle_pct;
    logic [31:0] rd;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_pool_reg();

    // single-entry pool straight out of reset
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd3, 1'b1, 4'd0));
    send_cmd(make_cmd(OP_MARK, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_MARK, 16'sd0, 1'b0, 4'd15));
    send_cmd(make_cmd(OP_RELEASE, 16'sd0, 1'b1, 4'd9));
    send_cmd(make_cmd(OP_RELEASE, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd3, 1'b1, 4'd0));
    drain();

    // full pool, plus a write to an unused register
    set_pool_size(5'd16);
    apb_access(1'b1, SPARE_ADDR, 32'd3, rd);
    check_pool_reg();
    send_cmd(make_cmd(OP_INIT, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, -16'sd1, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_MARK, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_RELEASE, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd7, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_MARK, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_RELEASE, 16'sd0, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd9, 1'b1, 4'd0));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd7, 1'b0, 4'd0));
    send_cmd(make_cmd(OP_RELEASE, 16'sd0, 1'b0, 4'd15));
    send_cmd(make_cmd(OP_MARK, 16'sd0, 1'b0, 4'd15));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sd32767, 1'b1, 4'd15));
    send_cmd(make_cmd(OP_ACQUIRE, 16'sh8000, 1'b0, 4'd15));
    send_cmd(make_cmd(OP_INIT, 16'sd0, 1'b1, 4'd15));

    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      set_pool_size(SEG_POOL[seg]);
      if (seg < 5) idle_pct = 18;
      else if (seg < 10) idle_pct = 81;
      else idle_pct = 0;
      // sometimes keep the old entries so the new size acts on a stale pool
      if ($urandom_range(3) != 0) send_cmd(make_cmd(OP_INIT, 16'sd0, 1'b0, 4'd0));
      for (k = 0; k < SEG_ITEMS; k++) begin
        send_cmd(random_cmd(board.live_entries()));
        if ($urandom_range(99) < idle_pct) hold_off($urandom_range(4, 1));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
